FILE: sv/bpde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpde_pkg
// Shared constants and helpers for the Bezier point and derivative evaluator.
// ----------------------------------------------------------------------------
package bpde_pkg;

  localparam int COORD_BITS_DEF  = 32;
  localparam int T_FRAC_BITS_DEF = 16;

  localparam int FUNC_BITS = 2;

  // curve order codes; every code other than these two is a cubic
  localparam logic [FUNC_BITS-1:0] ORD_LINEAR = 2'd0;
  localparam logic [FUNC_BITS-1:0] ORD_QUAD   = 2'd1;

  function automatic logic order_is_cubic(input logic [FUNC_BITS-1:0] ord);
    return (ord != ORD_LINEAR) && (ord != ORD_QUAD);
  endfunction

endpackage

FILE: sv/bezier_point_and_derivative_eval_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_point_and_derivative_eval_unit
// Linear, quadratic and cubic Bezier evaluation by de Casteljau lerps, with
// saturated first and second derivatives.
// ----------------------------------------------------------------------------
// Takes one segment word per cycle while the output side does not stall, and
// returns one result word per segment from the output register. The
// seven stages are the input register, then three pairs of a multiply stage
// (products of t and 1-t) and a sum/saturate stage, one pair per lerp level
// of the de Casteljau triangle; the last sum stage is the output register.
// Each stage holds its own valid bit and takes a new word whenever it is empty
// or its successor moves, so bubbles close up and a stall drops nothing.
// A t above 1.0 is clamped to 1.0; order code 3 is evaluated as a cubic.
// ----------------------------------------------------------------------------
module bezier_point_and_derivative_eval_unit #(
  parameter int COORD_BITS  = bpde_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = bpde_pkg::T_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // start_x, start_y, ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y, end_x, end_y, param_t
  input  logic [((8*COORD_BITS+T_FRAC_BITS+1+7)/8)*8-1:0] s_axis_tdata,
  // func
  input  logic [bpde_pkg::FUNC_BITS-1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // point_x, point_y, slope_x, slope_y, bend_x, bend_y
  output logic [((6*COORD_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int C    = COORD_BITS;
  localparam int F    = T_FRAC_BITS;
  localparam int TW   = F + 1;
  localparam int PW   = C + F + 1;
  localparam int WW   = C + 5;
  localparam int OB   = bpde_pkg::FUNC_BITS;
  localparam int NSTG = 7;

  localparam logic [TW-1:0] T_ONE = {1'b1, {F{1'b0}}};
  localparam logic signed [WW-1:0] MAX_W = {{(WW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [WW-1:0] MIN_W = {{(WW-C+1){1'b1}}, {(C-1){1'b0}}};

  function automatic logic signed [C-1:0] sat_c(input logic signed [WW-1:0] v);
    if (v > MAX_W) return MAX_W[C-1:0];
    if (v < MIN_W) return MIN_W[C-1:0];
    return v[C-1:0];
  endfunction

  // exact product of a coordinate and an unsigned fraction
  function automatic logic signed [PW-1:0] mul_t(input logic signed [C-1:0] a,
                                                 input logic [TW-1:0] t);
    return PW'(a) * $signed({{(PW-TW){1'b0}}, t});
  endfunction

  // floor each product by 2^F, add, saturate
  function automatic logic signed [C-1:0] lerp_sum(input logic signed [PW-1:0] pa,
                                                   input logic signed [PW-1:0] pb);
    logic signed [WW-1:0] s;
    s = WW'($signed(pa[F +: C])) + WW'($signed(pb[F +: C]));
    return sat_c(s);
  endfunction

  // ------------------------------------------------------------------ flow
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = ~vld[NSTG-1] | m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = ~vld[k] | adv[k+1];
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= s_axis_tvalid;
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ------------------------------------------------------------------ stage 0
  logic [OB-1:0]          ord0;
  logic signed [C-1:0]    pts0 [2][4];
  logic [TW-1:0]          tc0;
  logic [TW-1:0]          u0;
  logic [TW-1:0]          t_in;
  logic [TW-1:0]          t_clamp;

  assign t_in    = s_axis_tdata[8*C +: TW];
  assign t_clamp = (t_in > T_ONE) ? T_ONE : t_in;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ord0 <= s_axis_tuser;
      tc0  <= t_clamp;
      u0   <= T_ONE - t_clamp;
      for (int ax = 0; ax < 2; ax++) begin
        for (int p = 0; p < 4; p++) begin
          pts0[ax][p] <= s_axis_tdata[(2*p+ax)*C +: C];
        end
      end
    end
  end

  // ------------------------------------------------------------------ stage 1
  // first lerp level products; linear and quadratic reuse the outer slots
  logic [OB-1:0]          ord1;
  logic [TW-1:0]          tc1;
  logic [TW-1:0]          u1;
  logic signed [PW-1:0]   pr1 [2][6];
  logic signed [C-1:0]    slope1 [2];
  logic signed [C-1:0]    bend1 [2];
  logic signed [C-1:0]    op_b0 [2];
  logic signed [C-1:0]    op_a2 [2];

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      op_b0[ax] = (ord0 == bpde_pkg::ORD_LINEAR) ? pts0[ax][3] : pts0[ax][1];
      op_a2[ax] = (ord0 == bpde_pkg::ORD_QUAD) ? pts0[ax][1] : pts0[ax][2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ord1 <= ord0;
      tc1  <= tc0;
      u1   <= u0;
      for (int ax = 0; ax < 2; ax++) begin
        pr1[ax][0] <= mul_t(pts0[ax][0], u0);
        pr1[ax][1] <= mul_t(op_b0[ax], tc0);
        pr1[ax][2] <= mul_t(pts0[ax][1], u0);
        pr1[ax][3] <= mul_t(pts0[ax][2], tc0);
        pr1[ax][4] <= mul_t(op_a2[ax], u0);
        pr1[ax][5] <= mul_t(pts0[ax][3], tc0);
        slope1[ax] <= sat_c(WW'(pts0[ax][3]) - WW'(pts0[ax][0]));
        if (ord0 == bpde_pkg::ORD_LINEAR) begin
          bend1[ax] <= '0;
        end else begin
          bend1[ax] <= sat_c((WW'(pts0[ax][3]) - (WW'(pts0[ax][1]) <<< 1)
                              + WW'(pts0[ax][0])) <<< 1);
        end
      end
    end
  end

  // ------------------------------------------------------------------ stage 2
  logic [OB-1:0]          ord2;
  logic [TW-1:0]          tc2;
  logic [TW-1:0]          u2;
  logic signed [C-1:0]    lv1 [2][3];
  logic signed [C-1:0]    slope2 [2];
  logic signed [C-1:0]    bend2 [2];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      ord2 <= ord1;
      tc2  <= tc1;
      u2   <= u1;
      for (int ax = 0; ax < 2; ax++) begin
        lv1[ax][0]  <= lerp_sum(pr1[ax][0], pr1[ax][1]);
        lv1[ax][1]  <= lerp_sum(pr1[ax][2], pr1[ax][3]);
        lv1[ax][2]  <= lerp_sum(pr1[ax][4], pr1[ax][5]);
        slope2[ax]  <= slope1[ax];
        bend2[ax]   <= bend1[ax];
      end
    end
  end

  // ------------------------------------------------------------------ stage 3
  logic [OB-1:0]          ord3;
  logic [TW-1:0]          tc3;
  logic [TW-1:0]          u3;
  logic signed [PW-1:0]   pr3 [2][4];
  logic signed [C-1:0]    pt3 [2];
  logic signed [C-1:0]    slope3 [2];
  logic signed [C-1:0]    bend3 [2];
  logic signed [WW-1:0]   sec2 [2];

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      sec2[ax] = WW'(lv1[ax][2]) - (WW'(lv1[ax][1]) <<< 1) + WW'(lv1[ax][0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      ord3 <= ord2;
      tc3  <= tc2;
      u3   <= u2;
      for (int ax = 0; ax < 2; ax++) begin
        pr3[ax][0] <= mul_t(lv1[ax][0], u2);
        pr3[ax][1] <= mul_t((ord2 == bpde_pkg::ORD_QUAD) ? lv1[ax][2] : lv1[ax][1], tc2);
        pr3[ax][2] <= mul_t(lv1[ax][1], u2);
        pr3[ax][3] <= mul_t(lv1[ax][2], tc2);
        pt3[ax]    <= lv1[ax][0];
        if (ord2 == bpde_pkg::ORD_QUAD) begin
          slope3[ax] <= sat_c((WW'(lv1[ax][2]) - WW'(lv1[ax][0])) <<< 1);
        end else begin
          slope3[ax] <= slope2[ax];
        end
        if (bpde_pkg::order_is_cubic(ord2)) begin
          bend3[ax] <= sat_c((sec2[ax] <<< 2) + (sec2[ax] <<< 1));
        end else begin
          bend3[ax] <= bend2[ax];
        end
      end
    end
  end

  // ------------------------------------------------------------------ stage 4
  logic [OB-1:0]          ord4;
  logic [TW-1:0]          tc4;
  logic [TW-1:0]          u4;
  logic signed [C-1:0]    lv2 [2][2];
  logic signed [C-1:0]    pt4 [2];
  logic signed [C-1:0]    slope4 [2];
  logic signed [C-1:0]    bend4 [2];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      ord4 <= ord3;
      tc4  <= tc3;
      u4   <= u3;
      for (int ax = 0; ax < 2; ax++) begin
        lv2[ax][0] <= lerp_sum(pr3[ax][0], pr3[ax][1]);
        lv2[ax][1] <= lerp_sum(pr3[ax][2], pr3[ax][3]);
        pt4[ax]    <= pt3[ax];
        slope4[ax] <= slope3[ax];
        bend4[ax]  <= bend3[ax];
      end
    end
  end

  // ------------------------------------------------------------------ stage 5
  logic [OB-1:0]          ord5;
  logic signed [PW-1:0]   pr5 [2][2];
  logic signed [C-1:0]    pt5 [2];
  logic signed [C-1:0]    slope5 [2];
  logic signed [C-1:0]    bend5 [2];
  logic signed [WW-1:0]   dif4 [2];

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      dif4[ax] = WW'(lv2[ax][1]) - WW'(lv2[ax][0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      ord5 <= ord4;
      for (int ax = 0; ax < 2; ax++) begin
        pr5[ax][0] <= mul_t(lv2[ax][0], u4);
        pr5[ax][1] <= mul_t(lv2[ax][1], tc4);
        pt5[ax]    <= (ord4 == bpde_pkg::ORD_QUAD) ? lv2[ax][0] : pt4[ax];
        if (bpde_pkg::order_is_cubic(ord4)) begin
          slope5[ax] <= sat_c((dif4[ax] <<< 1) + dif4[ax]);
        end else begin
          slope5[ax] <= slope4[ax];
        end
        bend5[ax]  <= bend4[ax];
      end
    end
  end

  // ------------------------------------------------------------------ stage 6
  logic signed [C-1:0]    point6 [2];
  logic signed [C-1:0]    slope6 [2];
  logic signed [C-1:0]    bend6 [2];

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int ax = 0; ax < 2; ax++) begin
        if (bpde_pkg::order_is_cubic(ord5)) begin
          point6[ax] <= lerp_sum(pr5[ax][0], pr5[ax][1]);
        end else begin
          point6[ax] <= pt5[ax];
        end
        slope6[ax] <= slope5[ax];
        bend6[ax]  <= bend5[ax];
      end
    end
  end

  always_comb begin
    m_axis_tdata          = '0;
    m_axis_tdata[0*C +: C] = point6[0];
    m_axis_tdata[1*C +: C] = point6[1];
    m_axis_tdata[2*C +: C] = slope6[0];
    m_axis_tdata[3*C +: C] = slope6[1];
    m_axis_tdata[4*C +: C] = bend6[0];
    m_axis_tdata[5*C +: C] = bend6[1];
  end

endmodule

FILE: dv/bezier_point_and_derivative_eval_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_point_and_derivative_eval_unit_test
// Self-checking bench for the Bezier point and derivative evaluator.
// ----------------------------------------------------------------------------
// Drives linear, quadratic and cubic segments through the input stream and
// compares every result word, field by field, against an in-order queue of
// values computed here by de Casteljau lerps with floor truncation and
// saturated derivatives. A directed set of extreme segments comes first, then
// random segments. Both stream sides stall at random, except for one long
// stretch at full rate.
// ----------------------------------------------------------------------------
module bezier_point_and_derivative_eval_unit_test;

  localparam int CW = bpde_pkg::COORD_BITS_DEF;
  localparam int TF = bpde_pkg::T_FRAC_BITS_DEF;
  localparam int IN_W = ((8*CW+TF+1+7)/8)*8;
  localparam int OUT_W = ((6*CW+7)/8)*8;
  localparam longint T_ONE = longint'(1) << TF;
  localparam longint C_MAX = (longint'(1) << (CW-1)) - 1;
  localparam longint C_MIN = -C_MAX - 1;
  localparam int RANDOM_WORDS = 800;
  localparam int IDLE_PCT = 8;

  // order codes the package leaves unnamed; both evaluate as a cubic
  localparam logic [bpde_pkg::FUNC_BITS-1:0] ORD_CUBIC     = 2'd2;
  localparam logic [bpde_pkg::FUNC_BITS-1:0] ORD_CUBIC_ALT = 2'd3;

  // first field in the lowest bits
  typedef struct packed {
    logic [TF:0]   param_t;
    logic [CW-1:0] end_y, end_x, ctrl1_y, ctrl1_x, ctrl0_y, ctrl0_x, start_y, start_x;
  } segment_t;

  typedef struct packed {
    logic [CW-1:0] bend_y, bend_x, slope_y, slope_x, point_y, point_x;
  } curve_result_t;

  class bezier_eval_scoreboard;
    curve_result_t pending[$];
    int unsigned   errors = 0;

    function longint fit_coord(longint v);
      if (v > C_MAX) return C_MAX;
      if (v < C_MIN) return C_MIN;
      return v;
    endfunction

    // floor of each product, then saturate the sum
    function longint lerp_q(longint a, longint b, longint t);
      return fit_coord(((a * (T_ONE - t)) >>> TF) + ((b * t) >>> TF));
    endfunction

    function curve_result_t eval_segment(logic [bpde_pkg::FUNC_BITS-1:0] ord, segment_t seg);
      curve_result_t r;
      longint        sp[2], c0p[2], c1p[2], ep[2];
      longint        pt[2], d1[2], d2[2];
      longint        t, s0, sc, s1, ss0, ss1;
      t = seg.param_t;
      if (t > T_ONE) t = T_ONE;
      sp[0]  = longint'($signed(seg.start_x));
      sp[1]  = longint'($signed(seg.start_y));
      c0p[0] = longint'($signed(seg.ctrl0_x));
      c0p[1] = longint'($signed(seg.ctrl0_y));
      c1p[0] = longint'($signed(seg.ctrl1_x));
      c1p[1] = longint'($signed(seg.ctrl1_y));
      ep[0]  = longint'($signed(seg.end_x));
      ep[1]  = longint'($signed(seg.end_y));
      for (int ax = 0; ax < 2; ax++) begin
        case (ord)
          bpde_pkg::ORD_LINEAR: begin
            pt[ax] = lerp_q(sp[ax], ep[ax], t);
            d1[ax] = fit_coord(ep[ax] - sp[ax]);
            d2[ax] = 0;
          end
          bpde_pkg::ORD_QUAD: begin
            s0 = lerp_q(sp[ax], c0p[ax], t);
            s1 = lerp_q(c0p[ax], ep[ax], t);
            pt[ax] = lerp_q(s0, s1, t);
            d1[ax] = fit_coord(2 * (s1 - s0));
            d2[ax] = fit_coord(2 * (ep[ax] - 2 * c0p[ax] + sp[ax]));
          end
          default: begin
            s0  = lerp_q(sp[ax], c0p[ax], t);
            sc  = lerp_q(c0p[ax], c1p[ax], t);
            s1  = lerp_q(c1p[ax], ep[ax], t);
            ss0 = lerp_q(s0, sc, t);
            ss1 = lerp_q(sc, s1, t);
            pt[ax] = lerp_q(ss0, ss1, t);
            d1[ax] = fit_coord(3 * (ss1 - ss0));
            d2[ax] = fit_coord(6 * (s1 - 2 * sc + s0));
          end
        endcase
      end
      r.point_x = pt[0][CW-1:0];
      r.point_y = pt[1][CW-1:0];
      r.slope_x = d1[0][CW-1:0];
      r.slope_y = d1[1][CW-1:0];
      r.bend_x  = d2[0][CW-1:0];
      r.bend_y  = d2[1][CW-1:0];
      return r;
    endfunction

    function void note_segment(logic [bpde_pkg::FUNC_BITS-1:0] ord, segment_t seg);
      pending.push_back(eval_segment(ord, seg));
    endfunction

    function void compare_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(curve_result_t got);
      curve_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %h", $time, got);
        return;
      end
      want = pending.pop_front();
      compare_field("point_x", want.point_x, got.point_x);
      compare_field("point_y", want.point_y, got.point_y);
      compare_field("slope_x", want.slope_x, got.slope_x);
      compare_field("slope_y", want.slope_y, got.slope_y);
      compare_field("bend_x",  want.bend_x,  got.bend_x);
      compare_field("bend_y",  want.bend_y,  got.bend_y);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // start_x, start_y, ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y, end_x, end_y, param_t
  logic [IN_W-1:0]                s_axis_tdata = '0;
  // func
  logic [bpde_pkg::FUNC_BITS-1:0] s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // point_x, point_y, slope_x, slope_y, bend_x, bend_y
  logic [OUT_W-1:0]               m_axis_tdata;

  bezier_eval_scoreboard board = new();
  bit                    steady = 1'b0;

  bezier_point_and_derivative_eval_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      board.check_result(curve_result_t'(m_axis_tdata));
    end
  end

  // y mirrors x bitwise, so one extreme on x puts the opposite one on y
  function automatic segment_t make_seg(logic [CW-1:0] s, logic [CW-1:0] c0,
                                        logic [CW-1:0] c1, logic [CW-1:0] e,
                                        logic [TF:0] t);
    segment_t seg;
    seg.start_x = s;   seg.start_y = ~s;
    seg.ctrl0_x = c0;  seg.ctrl0_y = ~c0;
    seg.ctrl1_x = c1;  seg.ctrl1_y = ~c1;
    seg.end_x   = e;   seg.end_y   = ~e;
    seg.param_t = t;
    return seg;
  endfunction

  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(9))
      0:       return C_MIN[CW-1:0];
      1:       return C_MIN[CW-1:0] + CW'($urandom_range(3));
      2:       return C_MAX[CW-1:0] - CW'($urandom_range(3));
      3, 4, 5: return CW'($urandom());
      default: return CW'($signed(20'($urandom())));
    endcase
  endfunction

  function automatic logic [TF:0] pick_t();
    case ($urandom_range(19))
      0:       return '0;
      1:       return T_ONE[TF:0];
      2:       return (TF+1)'($urandom_range(2*T_ONE-1, T_ONE+1));
      default: return (TF+1)'($urandom_range(T_ONE));
    endcase
  endfunction

  function automatic segment_t random_seg();
    segment_t seg;
    seg.start_x = pick_coord();  seg.start_y = pick_coord();
    seg.ctrl0_x = pick_coord();  seg.ctrl0_y = pick_coord();
    seg.ctrl1_x = pick_coord();  seg.ctrl1_y = pick_coord();
    seg.end_x   = pick_coord();  seg.end_y   = pick_coord();
    seg.param_t = pick_t();
    return seg;
  endfunction

  task automatic push_segment(input logic [bpde_pkg::FUNC_BITS-1:0] ord, input segment_t seg);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(seg);
    s_axis_tuser  <= ord;
    // hold the word until the block takes it
    do @(posedge clk); while (!s_axis_tready);
    board.note_segment(ord, seg);
  endtask

  initial begin
    logic [CW-1:0] lo, hi;
    lo = C_MIN[CW-1:0];
    hi = C_MAX[CW-1:0];
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_segment(bpde_pkg::ORD_LINEAR, make_seg('0, '0, '0, '0, '0));
    push_segment(bpde_pkg::ORD_LINEAR, make_seg(lo, hi, lo, hi, '0));
    push_segment(bpde_pkg::ORD_LINEAR, make_seg(lo, hi, lo, hi, T_ONE[TF:0]));
    push_segment(bpde_pkg::ORD_LINEAR, make_seg(hi, lo, hi, lo, (TF+1)'(T_ONE/2)));
    push_segment(bpde_pkg::ORD_LINEAR, make_seg(lo + 1, lo, lo, lo, (TF+1)'(1)));
    push_segment(bpde_pkg::ORD_LINEAR, make_seg(lo, lo, lo, lo + 1, (TF+1)'(T_ONE-1)));
    push_segment(bpde_pkg::ORD_QUAD,   make_seg(lo, hi, lo, lo, (TF+1)'(T_ONE/2)));
    push_segment(bpde_pkg::ORD_QUAD,   make_seg(hi, lo, hi, hi, (TF+1)'(1)));
    push_segment(bpde_pkg::ORD_QUAD,   make_seg(lo + 1, lo + 1, lo, lo + 1, (TF+1)'(T_ONE-1)));
    push_segment(ORD_CUBIC,            make_seg(lo, hi, lo, hi, (TF+1)'(T_ONE/2)));
    push_segment(ORD_CUBIC,            make_seg(hi, lo, hi, lo, (TF+1)'(T_ONE/3)));
    push_segment(ORD_CUBIC,            make_seg(hi, hi, hi, hi, (TF+1)'(T_ONE-1)));
    push_segment(ORD_CUBIC,            make_seg(lo, lo + 1, lo, lo + 1, (TF+1)'(1)));
    push_segment(ORD_CUBIC_ALT,        make_seg(lo, hi, lo, hi, (TF+1)'(T_ONE/4)));
    push_segment(ORD_CUBIC_ALT,        random_seg());
    // t above one clamps to one
    push_segment(bpde_pkg::ORD_LINEAR, make_seg(lo, '0, '0, hi, (TF+1)'(T_ONE+1)));
    push_segment(ORD_CUBIC,            make_seg(hi, lo, lo, hi, '1));
    push_segment(bpde_pkg::ORD_QUAD,   make_seg(32'h0001_8000, 32'hFFFE_4000, '0, 32'h0003_0000,
                                                (TF+1)'(T_ONE-1)));
    push_segment(bpde_pkg::ORD_QUAD,   random_seg());
    push_segment(ORD_CUBIC,            random_seg());

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      steady = (n >= 300 && n < 450);
      push_segment(bpde_pkg::FUNC_BITS'($urandom_range(3)), random_seg());
    end
    steady = 1'b0;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    // catch stray words past the last expected one
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
sv/bpde_pkg.sv
sv/bezier_point_and_derivative_eval_unit.sv
dv/bezier_point_and_derivative_eval_unit_test.sv
